### rtl/set_operation_engine_unit_assert.svh
// Assertion macros for the set operation engine RTL, used in soe_back.
// Each expects clk and rst_n in the scope of the module that uses it.
`ifndef SET_OPERATION_ENGINE_UNIT_ASSERT_SVH
`define SET_OPERATION_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SOE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("set operation engine check failed");

// Next-cycle implication.
`define SOE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("set operation engine check failed");

`endif

### rtl/soe_pkg.sv
package soe_pkg;

    localparam int SET_CAPACITY = 8;
    localparam int MAX_RESULTS  = 64;
    localparam int ELEM_W       = 32;
    localparam int MODE_W       = 2;
    localparam int REQ_W        = 2;

    // Count holds 0..SET_CAPACITY, index holds 0..SET_CAPACITY-1
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_RUN    = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_PAIRS     = 2'd0,
        MODE_UNION     = 2'd1,
        MODE_INTERSECT = 2'd2,
        MODE_DIFF      = 2'd3
    } mode_t;

    typedef struct packed {
        req_t              kind;
        mode_t             mode;
        logic [ELEM_W-1:0] element;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cmdq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUTER,
        ST_OUTER_WAIT,
        ST_INNER_RD,
        ST_INNER_CMP,
        ST_FOUND,
        ST_FINISH
    } state_t;

endpackage

### rtl/soe_front.sv
module soe_front
    import soe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [ELEM_W-1:0] element,
    input  logic                     cfg_we,
    input  logic [MODE_W-1:0]        cfg_wdata,
    output logic                     q_push,
    output cmd_t                     q_cmd,
    input  cmdq_status_t             q_status
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [MODE_W-1:0] mode_reg;
    logic        in_xfer;

    assign q_push   = hold_valid_reg && !q_status.full;
    assign in_ready = !hold_valid_reg || !q_status.full;
    assign in_xfer  = in_valid && in_ready;
    assign q_cmd    = cmd_reg;

    // Classify the request; a run carries the mode in force when it arrived
    always_comb
    begin
        cmd_next.kind    = req_t'(req_type);
        cmd_next.mode    = mode_t'(mode_reg);
        cmd_next.element = element;
        if (cmd_next.kind != REQ_LOAD_A && cmd_next.kind != REQ_LOAD_B)
        begin
            cmd_next.element = '0;
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_xfer)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            mode_reg       <= MODE_W'(MODE_PAIRS);
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

### rtl/soe_cmdq.sv
module soe_cmdq
    import soe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cmd_t         push_cmd,
    input  logic         pop,
    output cmd_t         pop_cmd,
    output cmdq_status_t status
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CMDQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/soe_back.sv
`include "set_operation_engine_unit_assert.svh"

module soe_back
    import soe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmdq_status_t              q_status,
    input  cmd_t                      q_cmd,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ELEM_W-1:0]  result_element,
    output logic                      is_last,
    output logic                      is_empty
);

    logic [ELEM_W-1:0] store_a [SET_CAPACITY];
    logic [ELEM_W-1:0] store_b [SET_CAPACITY];
    logic [ELEM_W-1:0] rd_a_reg;
    logic [ELEM_W-1:0] rd_b_reg;
    logic [IDX_W-1:0]  a_addr;
    logic [IDX_W-1:0]  b_addr;
    logic              wr_a_en;
    logic              wr_b_en;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    mode_t             mode_reg, mode_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  oi_reg, oi_next;
    logic [CNT_W-1:0]  ii_reg, ii_next;
    logic              hit_reg, hit_next;
    logic [ELEM_W-1:0] outer_val_reg, outer_val_next;
    logic              pend_reg, pend_next;
    logic [ELEM_W-1:0] pend_val_reg, pend_val_next;
    logic [RES_W-1:0]  res_cnt_reg, res_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_elem_reg, out_elem_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;

    logic [CNT_W-1:0]  n_outer;
    logic [CNT_W-1:0]  n_inner;
    logic [ELEM_W-1:0] outer_rd;
    logic [ELEM_W-1:0] inner_val;
    logic              inner_eq;
    logic              inner_done;
    logic              outer_done;
    logic              want;
    logic              slot_free;
    logic              found_go;
    logic              cap_hit;

    // Phase one of union swaps roles: B is walked outside, A inside
    assign n_outer    = phase_reg ? cnt_b_reg : cnt_a_reg;
    assign n_inner    = phase_reg ? cnt_a_reg : cnt_b_reg;
    assign a_addr     = phase_reg ? ii_reg[IDX_W-1:0] : oi_reg[IDX_W-1:0];
    assign b_addr     = phase_reg ? oi_reg[IDX_W-1:0] : ii_reg[IDX_W-1:0];
    assign outer_rd   = phase_reg ? rd_b_reg : rd_a_reg;
    assign inner_val  = phase_reg ? rd_a_reg : rd_b_reg;
    assign inner_eq   = (inner_val == outer_val_reg);
    assign inner_done = (ii_reg >= n_inner);
    assign outer_done = (oi_reg >= n_outer);
    assign slot_free  = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign found_go   = (state_reg == ST_FOUND) && (!pend_reg || slot_free);
    assign cap_hit    = (res_cnt_reg == RES_W'(MAX_RESULTS - 1));

    always_comb
    begin
        unique case (mode_reg)
            MODE_INTERSECT: want = hit_reg;
            MODE_UNION:     want = !hit_reg;
            MODE_DIFF:      want = !hit_reg;
            default:        want = 1'b0;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign result_element = out_elem_reg;
    assign is_last        = out_last_reg;
    assign is_empty       = out_empty_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && q_cmd.kind == REQ_RUN)
                begin
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER:
            begin
                if (!outer_done)
                begin
                    state_next = ST_OUTER_WAIT;
                end
                else if (!(mode_reg == MODE_UNION && !phase_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_OUTER_WAIT:
            begin
                if (mode_reg == MODE_UNION && !phase_reg)
                begin
                    state_next = ST_FOUND;
                end
                else
                begin
                    state_next = ST_INNER_RD;
                end
            end
            ST_INNER_RD:
            begin
                if (!inner_done)
                begin
                    state_next = ST_INNER_CMP;
                end
                else if (want)
                begin
                    state_next = ST_FOUND;
                end
                else
                begin
                    state_next = ST_OUTER;
                end
            end
            ST_INNER_CMP:
            begin
                if (mode_reg == MODE_PAIRS && inner_eq)
                begin
                    state_next = ST_FOUND;
                end
                else
                begin
                    state_next = ST_INNER_RD;
                end
            end
            ST_FOUND:
            begin
                if (found_go)
                begin
                    if (cap_hit)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (mode_reg == MODE_PAIRS)
                    begin
                        state_next = ST_INNER_RD;
                    end
                    else
                    begin
                        state_next = ST_OUTER;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        oi_next        = oi_reg;
        ii_next        = ii_reg;
        hit_next       = hit_reg;
        outer_val_next = outer_val_reg;
        pend_next      = pend_reg;
        pend_val_next  = pend_val_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        wr_a_en        = 1'b0;
        wr_b_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_cmd.kind)
                        REQ_LOAD_A:
                        begin
                            if (cnt_a_reg < CNT_W'(SET_CAPACITY))
                            begin
                                wr_a_en    = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                        end
                        REQ_LOAD_B:
                        begin
                            if (cnt_b_reg < CNT_W'(SET_CAPACITY))
                            begin
                                wr_b_en    = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                        end
                        REQ_RUN:
                        begin
                            mode_next    = q_cmd.mode;
                            phase_next   = 1'b0;
                            oi_next      = '0;
                            res_cnt_next = '0;
                            pend_next    = 1'b0;
                        end
                        default:
                        begin
                            cnt_a_next = '0;
                            cnt_b_next = '0;
                        end
                    endcase
                end
            end
            ST_OUTER:
            begin
                if (outer_done && mode_reg == MODE_UNION && !phase_reg)
                begin
                    phase_next = 1'b1;
                    oi_next    = '0;
                end
            end
            ST_OUTER_WAIT:
            begin
                outer_val_next = outer_rd;
                ii_next        = '0;
                hit_next       = 1'b0;
            end
            ST_INNER_RD:
            begin
                if (inner_done && !want)
                begin
                    oi_next = oi_reg + CNT_W'(1);
                end
            end
            ST_INNER_CMP:
            begin
                ii_next = ii_reg + CNT_W'(1);
                if (inner_eq)
                begin
                    hit_next = 1'b1;
                end
            end
            ST_FOUND:
            begin
                if (found_go)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_elem_next  = pend_val_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_val_next = outer_val_reg;
                    res_cnt_next  = res_cnt_reg + RES_W'(1);
                    if (mode_reg != MODE_PAIRS)
                    begin
                        oi_next = oi_reg + CNT_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_empty_next = !pend_reg;
                    out_elem_next  = pend_reg ? pend_val_reg : '0;
                    pend_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            mode_reg      <= MODE_PAIRS;
            phase_reg     <= 1'b0;
            oi_reg        <= '0;
            ii_reg        <= '0;
            hit_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            res_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            oi_reg        <= oi_next;
            ii_reg        <= ii_next;
            hit_reg       <= hit_next;
            pend_reg      <= pend_next;
            res_cnt_reg   <= res_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outer_val_reg <= outer_val_next;
        pend_val_reg  <= pend_val_next;
        out_elem_reg  <= out_elem_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    // Element stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            store_a[cnt_a_reg[IDX_W-1:0]] <= q_cmd.element;
        end
        if (wr_b_en)
        begin
            store_b[cnt_b_reg[IDX_W-1:0]] <= q_cmd.element;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= store_a[a_addr];
        rd_b_reg <= store_b[b_addr];
    end

    `SOE_ASSERT_IMP(a_empty_is_last, out_valid_reg && out_empty_reg, out_last_reg && (out_elem_reg == '0))
    `SOE_ASSERT_IMP(a_idle_no_pending, state_reg == ST_IDLE, !pend_reg)
    `SOE_ASSERT_NXT(a_cmp_after_rd, state_reg == ST_INNER_RD && !inner_done, state_reg == ST_INNER_CMP)
    `SOE_ASSERT_IMP(a_counts_bounded, 1'b1, (cnt_a_reg <= CNT_W'(SET_CAPACITY)) && (cnt_b_reg <= CNT_W'(SET_CAPACITY)))

endmodule

### rtl/set_operation_engine_unit.sv
// Loads, clears: applied as the idle back end pops them; one transfer per cycle while in_ready.
// Run: per outer element a store read, then per A-B comparison a registered read and a compare,
//   then a step per result found; union copies A first, then switches to B.
// Output stalls hold the run; each result leaves once the next is found, the last at run end.
// Reset (rst_n, asynchronous, active low): both lists empty, op_mode 0, queue and outputs idle;
//   store contents are not cleared and need no clearing pass.
module set_operation_engine_unit
    import soe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ELEM_W-1:0] result_element,
    output logic                     is_last,
    output logic                     is_empty,
    input  logic                     cfg_we,
    input  logic [MODE_W-1:0]        cfg_wdata
);

    // Front to queue
    logic         q_push;
    cmd_t         q_push_cmd;
    // Queue to back
    logic         q_pop;
    cmd_t         q_pop_cmd;
    cmdq_status_t q_status;

    // Front: hold op_mode, accept a transfer, classify it and stage it for the queue.
    // A run takes its mode with it, so the back end never reads the register directly.
    soe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .element   (element),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd),
        .q_status  (q_status)
    );

    // Short command queue: lets loads keep arriving while a run is still streaming results.
    soe_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .status   (q_status)
    );

    // Back: own both element stores, apply loads and clears, and sequence a run
    // through an outer/inner walk, feeding the output register.
    soe_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .q_cmd          (q_pop_cmd),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_element (result_element),
        .is_last        (is_last),
        .is_empty       (is_empty)
    );

endmodule
